### design/ssd_pkg.sv
package ssd_pkg;

	typedef enum logic [2:0] {
		REQ_TICK   = 3'd0,
		REQ_NUMBER = 3'd1,
		REQ_TEXT   = 3'd2,
		REQ_RAW    = 3'd3,
		REQ_DOT    = 3'd4,
		REQ_CLEAR  = 3'd5
	} ssd_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV0,
		ST_DIV1,
		ST_DIV2,
		ST_ENC
	} ssd_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       tick;
		logic       num_load;
		logic       text;
		logic       raw;
		logic       dot;
		logic       clear;
		logic       div_step;
		logic [1:0] div_digit;
		logic       encode;
	} ssd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_stall;
		logic pos_ok;
	} ssd_status_t;

	localparam logic [16:0] DIV_RECIP  = 17'd52429;  // 2^19 / 10, rounded up
	localparam logic [9:0]  RAMP_TOP   = 10'd640;
	localparam logic [9:0]  RAMP_STEP  = 10'd8;
	localparam logic [7:0]  BLANK_CODE = 8'hFF;
	localparam logic [7:0]  DOT_SEG    = 8'h10;

	// Character code to active-low segment pattern.
	function automatic logic [7:0] encode_char(input logic [7:0] code, input logic dot);
		logic [7:0] lit;
		logic       blank;
		logic [7:0] pat;
		blank = 1'b0;
		case (code)
			8'd0:  lit = 8'hAF;
			8'd1:  lit = 8'hA0;
			8'd2:  lit = 8'hC7;
			8'd3:  lit = 8'hE5;
			8'd4:  lit = 8'hE8;
			8'd5:  lit = 8'h6D;
			8'd6:  lit = 8'h6F;
			8'd7:  lit = 8'hA1;
			8'd8:  lit = 8'hEF;
			8'd9:  lit = 8'hE9;
			8'h2D: lit = 8'h40;  // minus
			8'h2E: lit = 8'h10;  // period
			8'h41: lit = 8'hEB;
			8'h42: lit = 8'h6E;
			8'h43: lit = 8'h0F;
			8'h44: lit = 8'hE6;
			8'h45: lit = 8'h4F;
			8'h46: lit = 8'h4B;
			8'h47: lit = 8'h6F;
			8'h48: lit = 8'h6A;
			8'h49: lit = 8'h20;
			8'h4C: lit = 8'h0E;
			8'h4E: lit = 8'hAB;
			8'h4F: lit = 8'h66;
			8'h50: lit = 8'hCB;
			8'h52: lit = 8'h42;
			8'h53: lit = 8'h6D;
			8'h54: lit = 8'h4E;
			8'h55: lit = 8'h26;
			8'h56: lit = 8'h26;
			8'h2A: lit = 8'hC9;  // asterisk
			8'h20, 8'hFF: begin
				lit   = 8'h00;
				blank = 1'b1;
			end
			default: lit = 8'h10;
		endcase
		pat = blank ? 8'hFF : ~lit;
		if (dot) begin
			pat = pat & ~DOT_SEG;
		end
		return pat;
	endfunction

endpackage

### design/ssd_ctrl.sv
module ssd_ctrl import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic [2:0]  req_type,
	output logic        s_tready,
	input  ssd_status_t status,
	output ssd_cmd_t    cmd
);

	ssd_state_t state_q;
	ssd_state_t state_n;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE) && !status.out_stall;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_NUMBER:            state_n = ST_DIV0;
						REQ_TEXT, REQ_CLEAR:   state_n = ST_ENC;
						REQ_DOT: begin
							if (status.pos_ok) state_n = ST_ENC;
						end
						default:               state_n = ST_IDLE;
					endcase
				end
			end
			ST_DIV0: state_n = ST_DIV1;
			ST_DIV1: state_n = ST_DIV2;
			ST_DIV2: state_n = ST_ENC;
			ST_ENC:  state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_TICK:   cmd.tick     = 1'b1;
						REQ_NUMBER: cmd.num_load = 1'b1;
						REQ_TEXT:   cmd.text     = 1'b1;
						REQ_RAW:    cmd.raw      = 1'b1;
						REQ_DOT:    cmd.dot      = 1'b1;
						REQ_CLEAR:  cmd.clear    = 1'b1;
						default:    cmd          = '0;
					endcase
				end
			end
			ST_DIV0: begin
				cmd.div_step  = 1'b1;
				cmd.div_digit = 2'd0;
			end
			ST_DIV1: begin
				cmd.div_step  = 1'b1;
				cmd.div_digit = 2'd1;
			end
			ST_DIV2: begin
				cmd.div_step  = 1'b1;
				cmd.div_digit = 2'd2;
			end
			ST_ENC:  cmd.encode = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

### design/ssd_datapath.sv
module ssd_datapath import ssd_pkg::*; #(
	parameter int DIGIT_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ssd_cmd_t    cmd,
	output ssd_status_t status,
	input  logic [15:0] number_value,
	input  logic [7:0]  text_first,
	input  logic [7:0]  text_second,
	input  logic [7:0]  text_third,
	input  logic [1:0]  position,
	input  logic [7:0]  raw_code,
	input  logic        dot_value,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [23:0] m_tdata
);

	localparam int DW        = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int IW        = DW + 3;
	localparam int SCAN_LAST = 8 * DIGIT_COUNT - 1;

	logic [7:0]    codes_q    [DIGIT_COUNT];
	logic          dots_q     [DIGIT_COUNT];
	logic [7:0]    patterns_q [DIGIT_COUNT];
	logic [IW-1:0] scan_q;
	logic [9:0]    cmp_q;
	logic [16:0]   work_q;
	logic          m_tvalid_q;
	logic [23:0]   m_tdata_q;

	logic [IW-1:0] scan_n;
	logic [DW-1:0] digit_sel;
	logic [7:0]    seg_mask;
	logic [7:0]    onehot;
	logic [7:0]    seg;
	logic [9:0]    cmp_n;
	logic [33:0]   prod;
	logic [14:0]   quot;
	logic [17:0]   quot10;
	logic [3:0]    rem;
	logic          neg;
	logic [16:0]   mag;
	logic [7:0]    txt  [3];
	logic          run  [3];
	logic [7:0]    text_codes [DIGIT_COUNT];
	logic          pos_ok;

	// scan advance and segment select
	assign scan_n    = (scan_q == IW'(SCAN_LAST)) ? '0 : scan_q + 1'b1;
	assign digit_sel = scan_n[IW-1:3];
	assign seg_mask  = ~(8'd1 << scan_n[2:0]);
	assign onehot    = 8'd1 << digit_sel;
	assign seg       = patterns_q[digit_sel] | seg_mask;
	assign cmp_n     = (cmp_q == RAMP_TOP) ? RAMP_STEP : cmp_q + RAMP_STEP;

	// divide by ten through the reciprocal; exact for values below 2^17
	assign prod   = 34'(work_q) * 34'(DIV_RECIP);
	assign quot   = prod[33:19];
	assign quot10 = 18'({quot, 3'b000}) + 18'({quot, 1'b0});
	assign rem    = work_q[3:0] - quot10[3:0];

	assign neg = number_value[15];
	assign mag = neg ? (17'h10000 - {1'b0, number_value}) : {1'b0, number_value};

	assign pos_ok           = int'(position) < DIGIT_COUNT;
	assign status.pos_ok    = pos_ok;
	assign status.out_stall = m_tvalid_q && !m_tready;

	// text fills from the leftmost digit, stopping at the first zero code
	always_comb begin
		int k;
		txt[0] = text_first;
		txt[1] = text_second;
		txt[2] = text_third;
		run[0] = (text_first != 8'd0);
		run[1] = run[0] && (text_second != 8'd0);
		run[2] = run[1] && (text_third != 8'd0);
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			k = DIGIT_COUNT - 1 - i;
			text_codes[i] = BLANK_CODE;
			if (k < 3) begin
				if (run[k[1:0]]) text_codes[i] = txt[k[1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				codes_q[i]    <= 8'd0;
				dots_q[i]     <= 1'b0;
				patterns_q[i] <= 8'hFF;
			end
			scan_q     <= '0;
			cmp_q      <= '0;
			work_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cmd.tick) begin
				scan_q     <= scan_n;
				cmp_q      <= cmp_n;
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {3'b000, cmp_n, onehot[2:0], seg};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (cmd.num_load) begin
				work_q <= mag;
				for (int i = 0; i < DIGIT_COUNT; i++) begin
					if (neg) dots_q[i] <= 1'b1;
					else if (i != 0) dots_q[i] <= 1'b0;
				end
			end

			if (cmd.div_step) begin
				work_q <= {2'b00, quot};
				for (int i = 0; i < DIGIT_COUNT; i++) begin
					if (int'(cmd.div_digit) == i) codes_q[i] <= {4'd0, rem};
				end
			end

			if (cmd.text) begin
				for (int i = 0; i < DIGIT_COUNT; i++) begin
					codes_q[i] <= text_codes[i];
					dots_q[i]  <= 1'b0;
				end
			end

			if (cmd.clear) begin
				for (int i = 0; i < DIGIT_COUNT; i++) begin
					codes_q[i] <= BLANK_CODE;
					dots_q[i]  <= 1'b0;
				end
			end

			if (cmd.dot) begin
				for (int i = 0; i < DIGIT_COUNT; i++) begin
					if (int'(position) == i) dots_q[i] <= dot_value;
				end
			end

			if (cmd.raw) begin
				for (int i = 0; i < DIGIT_COUNT; i++) begin
					if (int'(position) == i) patterns_q[i] <= encode_char(raw_code, dot_value);
				end
			end

			if (cmd.encode) begin
				for (int i = 0; i < DIGIT_COUNT; i++) begin
					patterns_q[i] <= encode_char(codes_q[i], dots_q[i]);
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### design/seven_segment_scan_display_core.sv
// Multiplexed seven-segment driver, one segment of one digit lit per scan tick.
// Input stream: s_tuser carries the request kind (tick, number, text, raw char,
// dot write, clear); s_tdata carries the request operands. One word per request.
// Output stream: each tick request yields one word with the active-low segment
// byte, the one-hot digit enable and the next timer compare value (8..640).
// Every other request yields no output word.
// Sequencing: a tick, raw char write or unknown request completes in the idle state,
// and a tick's output word is registered and valid the cycle after acceptance.
// A text, clear or in-range dot write runs as an update, then a re-encode of
// all digits through the character table. A number runs as one load, three
// divide-by-ten steps on the shared reciprocal multiplier and one re-encode.
// s_tready stays low while those steps run.
// Reset clears all codes and dots, blanks every pattern and zeroes the scan
// index and the compare ramp; no output word is pending after reset.
// When the receiver stalls, the output word holds and further requests wait
// until the pending word is taken; a word taken in the same cycle frees the
// slot for the next tick at once.
module seven_segment_scan_display_core import ssd_pkg::*; #(
	parameter int DIGIT_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// number_value[15:0], text_first[23:16], text_second[31:24], text_third[39:32],
	// position[41:40], raw_code[49:42], dot_value[50], zero fill[55:51]
	input  logic [55:0] s_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// segment_bits[7:0], digit_enable[10:8], compare_value[20:11], zero fill[23:21]
	output logic [23:0] m_tdata
);

	ssd_cmd_t    cmd;
	ssd_status_t status;

	// controller: sequence each request, drive handshake toward the source
	ssd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.req_type (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: display state, digit split, encoder and output register
	ssd_datapath #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.number_value (s_tdata[15:0]),
		.text_first   (s_tdata[23:16]),
		.text_second  (s_tdata[31:24]),
		.text_third   (s_tdata[39:32]),
		.position     (s_tdata[41:40]),
		.raw_code     (s_tdata[49:42]),
		.dot_value    (s_tdata[50]),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.m_tdata      (m_tdata)
	);

	// a number request holds off the next word while the digits are split
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == REQ_NUMBER) |=> !s_tready)
		else $error("input accepted during digit split");

	// a tick always produces an output word on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == REQ_TICK) |=> m_tvalid)
		else $error("tick accepted without output word");

	// compare ramp stays on multiples of 8 within 8..640
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:11] == 3'd0 && m_tdata[20:11] != 10'd0
			&& m_tdata[20:11] <= RAMP_TOP))
		else $error("compare value off ramp");

	// at most one digit enabled per output word
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[10:8]))
		else $error("digit enable not one-hot");

endmodule
